// ===== rtl/tatu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatu_pkg
// Shared constants, register indexes, status codes and the configuration
// snapshot type for the thermistor conversion pipeline.
// ----------------------------------------------------------------------------
package tatu_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_COEF_A  = 3'd0;
    localparam logic [2:0] REG_COEF_B  = 3'd1;
    localparam logic [2:0] REG_COEF_D  = 3'd2;
    localparam logic [2:0] REG_REF_RES = 3'd3;
    localparam logic [2:0] REG_STEP    = 3'd4;
    localparam logic [2:0] REG_OFFSET  = 3'd5;
    localparam logic [2:0] REG_SUPPLY  = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LOW  = 2'd1;
    localparam logic [1:0] ST_HIGH = 2'd2;

    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [21:0] TEMP_MAX  = 22'd2000000;
    localparam logic [18:0] ZERO_C_MK = 19'd273150;
    localparam logic [61:0] KELVIN_NUM = 62'd4096000000000000000;

    // Configuration snapshot.
    typedef struct packed {
        logic [31:0] coef_a;
        logic [31:0] coef_b;
        logic [31:0] coef_d;
        logic [19:0] ref_res;
        logic [13:0] step_uv;
        logic [11:0] offset_mv;
        logic [12:0] supply_mv;
    } t_cfg;

endpackage

// ===== rtl/tatu_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatu_div
// Pipelined restoring divider: one quotient bit per stage, with a side band
// carried along each stage. Stages advance together on i_en.
// ----------------------------------------------------------------------------
module tatu_div #(
    parameter int NW = 52,
    parameter int DW = 23,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic [NW-1:0] o_quo,
    output logic          o_rem_nz,
    output logic [SW-1:0] o_side
);

    // Entry g holds the state after quotient bit g has been decided.
    logic [NW-1:0] r_num  [NW];
    logic [DW:0]   r_rem  [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];

    // One quotient bit per stage, quotient shifted into the numerator word.
    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [NW-1:0] w_num;
        logic [DW:0]   w_rem;
        logic [DW-1:0] w_den;
        logic [SW-1:0] w_side;
        logic [DW+1:0] w_try;
        logic [DW+1:0] w_sub;

        // The first stage takes the request, later stages the stage before.
        if (g == 0) begin : g_head
            assign w_num  = i_num;
            assign w_rem  = '0;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_tail
            assign w_num  = r_num[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_den  = r_den[g-1];
            assign w_side = r_side[g-1];
        end

        always_comb begin
            w_try = {w_rem, w_num[NW-1]};
            w_sub = w_try - {2'b00, w_den};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_sub[DW+1]) begin
                    r_rem[g] <= w_sub[DW:0];
                end else begin
                    r_rem[g] <= w_try[DW:0];
                end
                r_num[g]  <= {w_num[NW-2:0], ~w_sub[DW+1]};
                r_den[g]  <= w_den;
                r_side[g] <= w_side;
            end
        end
    end

    assign o_quo    = r_num[NW-1];
    assign o_rem_nz = |r_rem[NW-1];
    assign o_side   = r_side[NW-1];

endmodule

// ===== rtl/tatu_log.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatu_log
// Pipelined natural log of a Q16 resistance: leading-one stage, one
// mantissa squaring per fraction bit, then the ln2 scaling.
// ----------------------------------------------------------------------------
module tatu_log #(
    parameter int FB = 24,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [47:0]   i_x,
    input  logic [SW-1:0] i_side,
    output logic [47:0]   o_lmag,
    output logic          o_neg,
    output logic [SW-1:0] o_side
);

    localparam logic [29:0] LN2_Q30_W = tatu_pkg::LN2_Q30;

    logic [5:0]    w_p;
    logic [31:0]   r_m    [FB+1];
    logic [FB-1:0] r_fr   [FB+1];
    logic [5:0]    r_p    [FB+1];
    logic [SW-1:0] r_side [FB+1];

    // Leading one position.
    always_comb begin
        w_p = 6'd0;
        for (int i = 1; i < 48; i++) begin
            if (i_x[i]) begin
                w_p = 6'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_p >= 6'd30) begin
                r_m[0] <= 32'(i_x >> (w_p - 6'd30));
            end else begin
                r_m[0] <= 32'(i_x << (6'd30 - w_p));
            end
            r_fr[0]   <= '0;
            r_p[0]    <= w_p;
            r_side[0] <= i_side;
        end
    end

    // One squaring per fraction bit.
    for (genvar g = 0; g < FB; g++) begin : g_sq
        logic [63:0] w_sq;
        logic [33:0] w_m;
        always_comb begin
            w_sq = 64'(r_m[g]) * 64'(r_m[g]);
            w_m  = w_sq[63:30];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_m[31]) begin
                    r_m[g+1]  <= 32'(w_m >> 1);
                    r_fr[g+1] <= {r_fr[g][FB-2:0], 1'b1};
                end else begin
                    r_m[g+1]  <= w_m[31:0];
                    r_fr[g+1] <= {r_fr[g][FB-2:0], 1'b0};
                end
                r_p[g+1]    <= r_p[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    // Signed log2 magnitude.
    localparam int QW = FB + 6;
    logic [QW-1:0] w_q;
    logic          w_neg;
    always_comb begin
        w_neg = r_p[FB] < 6'd16;
        if (w_neg) begin
            w_q = (QW'(6'd16 - r_p[FB]) << FB) - QW'(r_fr[FB]);
        end else begin
            w_q = (QW'(r_p[FB] - 6'd16) << FB) + QW'(r_fr[FB]);
        end
    end

    // ln2 scaling, split into two products.
    logic [63:0]   r_hi;
    logic [47:0]   r_lo;
    logic          r_neg;
    logic [SW-1:0] r_side2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi    <= 64'(w_q >> 16) * 64'(LN2_Q30_W);
            r_lo    <= 48'(w_q[15:0]) * 48'(LN2_Q30_W);
            r_neg   <= w_neg;
            r_side2 <= r_side[FB];
        end
    end

    logic [63:0] w_ln;
    always_comb begin
        w_ln = (r_hi + 64'(r_lo >> 16)) >> 14;
        w_ln = w_ln >> (FB - 16);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lmag <= w_ln[47:0];
            o_neg  <= r_neg;
            o_side <= r_side2;
        end
    end

endmodule

// ===== rtl/thermistor_adc_to_temperature_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_unit
// ADC code to millidegrees Celsius through a divider solve and the
// Steinhart-Hart form, as one stall-able pipeline.
// ----------------------------------------------------------------------------
// Steps run in order: input stages, resistance divide, log, powers and
// coefficient products, kelvin divide, output. Throughput is one request
// per cycle while the output is not stalled. The whole pipeline advances together and stalls as one on
// i_out_stall. Synchronous active-low reset clears valid bits and loads the
// register reset values; no clearing pass is needed.
module thermistor_adc_to_temperature_unit #(
    parameter int ADC_BITS     = 12,
    parameter int LN_FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [11:0]        i_adc_code,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [21:0] o_temp_millideg,
    output logic [1:0]         o_status
);

    localparam int LAT_R = 59;
    localparam int LAT_L = LN_FRAC_BITS + 3;
    localparam int LAT_K = 62;
    localparam int NV    = 4 + LAT_R + LAT_L + 4 + LAT_K + 2;

    tatu_pkg::t_cfg r_cfg;
    logic           w_en;
    logic [NV-1:0]  r_vld;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_a    <= 32'd1125000000;
            r_cfg.coef_b    <= 32'd234700000;
            r_cfg.coef_d    <= 32'd85660;
            r_cfg.ref_res   <= 20'd50000;
            r_cfg.step_uv   <= 14'd500;
            r_cfg.offset_mv <= 12'd88;
            r_cfg.supply_mv <= 13'd3300;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tatu_pkg::REG_COEF_A:  r_cfg.coef_a    <= i_cfg_data;
                tatu_pkg::REG_COEF_B:  r_cfg.coef_b    <= i_cfg_data;
                tatu_pkg::REG_COEF_D:  r_cfg.coef_d    <= i_cfg_data;
                tatu_pkg::REG_REF_RES: r_cfg.ref_res   <= i_cfg_data[19:0];
                tatu_pkg::REG_STEP:    r_cfg.step_uv   <= i_cfg_data[13:0];
                tatu_pkg::REG_OFFSET:  r_cfg.offset_mv <= i_cfg_data[11:0];
                tatu_pkg::REG_SUPPLY:  r_cfg.supply_mv <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output is free or empty.
    assign w_en       = !(r_vld[NV-1] && i_out_stall);
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], i_in_valid};
        end
    end

    // Only the low ADC_BITS bits of the code take part.
    logic [11:0] w_code;
    assign w_code = i_adc_code & 12'((1 << ADC_BITS) - 1);

    // Stage 1: voltage in microvolts and supply in microvolts.
    logic signed [27:0] r_v1;
    logic [22:0]        r_sup1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v1   <= $signed({2'b00, 26'(r_cfg.step_uv) * 26'(w_code)})
                    - $signed({6'd0, 22'(r_cfg.offset_mv) * 22'd1000});
            r_sup1 <= 23'(r_cfg.supply_mv) * 23'd1000;
        end
    end

    // Stage 2: range checks and divider difference.
    logic [1:0]  r_st2;
    logic [22:0] r_v2;
    logic [22:0] r_den2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_v1 <= 0) begin
                r_st2 <= tatu_pkg::ST_LOW;
            end else if (r_v1 >= $signed({5'd0, r_sup1})) begin
                r_st2 <= tatu_pkg::ST_HIGH;
            end else begin
                r_st2 <= tatu_pkg::ST_OK;
            end
            r_v2   <= r_v1[22:0];
            r_den2 <= r_sup1 - r_v1[22:0];
        end
    end

    // Stage 3: v times the reference resistor.
    logic [42:0] r_p3;
    logic [1:0]  r_st3;
    logic [22:0] r_den3;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3   <= 43'(r_v2) * 43'(r_cfg.ref_res);
            r_st3  <= r_st2;
            r_den3 <= (r_st2 == tatu_pkg::ST_OK) ? r_den2 : 23'd1;
        end
    end

    // Stage 4 + divider: Q16 resistance.
    logic [58:0] r_num4;
    logic [22:0] r_den4;
    logic [1:0]  r_st4;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num4 <= {r_p3, 16'd0};
            r_den4 <= r_den3;
            r_st4  <= r_st3;
        end
    end

    logic [58:0] w_rq;
    logic        w_rq_rnz;
    logic [1:0]  w_st_r;
    tatu_div #(.NW(59), .DW(23), .SW(2)) u_rdiv (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (r_num4),
        .i_den   (r_den4),
        .i_side  (r_st4),
        .o_quo   (w_rq),
        .o_rem_nz(w_rq_rnz),
        .o_side  (w_st_r)
    );

    // Clamp the resistance to [1, 2^48-1].
    logic [47:0] w_rqc;
    always_comb begin
        if (w_rq == '0) begin
            w_rqc = 48'd1;
        end else if (|w_rq[58:48]) begin
            w_rqc = '1;
        end else begin
            w_rqc = w_rq[47:0];
        end
    end

    logic [47:0] w_lmag;
    logic        w_lneg;
    logic [1:0]  w_st_l;
    tatu_log #(.FB(LN_FRAC_BITS), .SW(2)) u_log (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_rqc),
        .i_side(w_st_r),
        .o_lmag(w_lmag),
        .o_neg (w_lneg),
        .o_side(w_st_l)
    );

    // Powers of lnR: square, then cube.
    logic [47:0] r_m1;
    logic [47:0] r_l2;
    logic        r_neg1;
    logic [1:0]  r_sta;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1   <= w_lmag;
            r_l2   <= 48'((64'(w_lmag[31:0]) * 64'(w_lmag[31:0])) >> 16);
            r_neg1 <= w_lneg;
            r_sta  <= w_st_l;
        end
    end

    logic [47:0] r_m2;
    logic [47:0] r_l3;
    logic        r_neg2;
    logic [1:0]  r_stb;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2   <= r_m1;
            r_l3   <= 48'((64'(r_l2[31:0]) * 64'(r_m1[31:0])) >> 16);
            r_neg2 <= r_neg1;
            r_stb  <= r_sta;
        end
    end

    // Coefficient products.
    logic [63:0] r_bl;
    logic [63:0] r_dl;
    logic        r_neg3;
    logic [1:0]  r_stc;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bl   <= 64'(r_cfg.coef_b) * 64'(r_m2[31:0]);
            r_dl   <= 64'(r_cfg.coef_d) * 64'(r_l3[31:0]);
            r_neg3 <= r_neg2;
            r_stc  <= r_stb;
        end
    end

    // Denominator sum and divide by 16.
    logic signed [66:0] w_s;
    logic [61:0]        r_s4;
    logic               r_sat;
    logic [1:0]         r_std;
    always_comb begin
        if (r_neg3) begin
            w_s = $signed({3'd0, 16'd0, r_cfg.coef_a, 16'd0}) - $signed({3'd0, r_bl})
                - $signed({3'd0, r_dl});
        end else begin
            w_s = $signed({3'd0, 16'd0, r_cfg.coef_a, 16'd0}) + $signed({3'd0, r_bl})
                + $signed({3'd0, r_dl});
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sat <= (w_s < 67'sd16);
            r_s4  <= (w_s < 67'sd16) ? 62'd1 : 62'(w_s >>> 4);
            r_std <= r_stc;
        end
    end

    logic [61:0] w_quo;
    logic        w_rnz;
    logic [2:0]  w_side_k;
    tatu_div #(.NW(62), .DW(62), .SW(3)) u_kdiv (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (tatu_pkg::KELVIN_NUM),
        .i_den   (r_s4),
        .i_side  ({r_sat, r_std}),
        .o_quo   (w_quo),
        .o_rem_nz(w_rnz),
        .o_side  (w_side_k)
    );

    // Offset to Celsius with saturation.
    logic signed [22:0] r_t;
    logic               r_tsat;
    logic [1:0]         r_ste;
    logic [61:0]        w_diff;
    always_comb begin
        w_diff = w_quo - 62'(tatu_pkg::ZERO_C_MK);
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ste <= w_side_k[1:0];
            if (w_quo >= 62'(tatu_pkg::ZERO_C_MK)) begin
                r_tsat <= w_side_k[2] || (w_diff > 62'(tatu_pkg::TEMP_MAX));
                r_t    <= 23'(w_diff[21:0]);
            end else begin
                r_tsat <= w_side_k[2];
                r_t    <= $signed({4'd0, w_quo[18:0]}) - $signed({4'd0, tatu_pkg::ZERO_C_MK})
                        + (w_rnz ? 23'sd1 : 23'sd0);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_status <= r_ste;
            if (r_ste != tatu_pkg::ST_OK) begin
                o_temp_millideg <= '0;
            end else if (r_tsat) begin
                o_temp_millideg <= $signed(tatu_pkg::TEMP_MAX);
            end else begin
                o_temp_millideg <= r_t[21:0];
            end
        end
    end

    assign o_out_valid = r_vld[NV-1];

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_temp_millideg))
        else $error("result changed under stall");

    // Errors always carry zero temperature.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != tatu_pkg::ST_OK |-> o_temp_millideg == '0)
        else $error("error result with nonzero temperature");

    // Input is held off exactly when the result is blocked.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall mismatch");

endmodule
